// File: rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, active during reset as well
`define ASSERT_CLK(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Clocked assertion, switched off while the active-low reset is applied
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// File: rtl/v3alu_pkg.sv
// Package: operation codes and fixed constants of the vector unit.
`default_nettype none
package v3alu_pkg;

    localparam int KIND_W = 3;

    // Operation selector carried in the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_SCALE = 3'd2,
        KIND_CROSS = 3'd3,
        KIND_MAG   = 3'd4,
        KIND_NORM  = 3'd5,
        KIND_NEG   = 3'd6,
        KIND_NOP   = 3'd7
    } t_kind;

    // Bit positions in the output tuser
    localparam int USER_OVF   = 0;
    localparam int USER_ZLEN  = 1;
    localparam int OUT_USER_W = 2;

endpackage
`default_nettype wire

// File: rtl/v3alu_delay.sv
// Enable-gated register line that keeps side data aligned with the long units.
`default_nettype none
module v3alu_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_line [DEPTH];

    // shift one place per advancing cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_line[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_line[k] <= r_line[k-1];
            end
        end
    end

    assign o_q = r_line[DEPTH-1];
endmodule
`default_nettype wire

// File: rtl/v3alu_lane.sv
// One component lane: products, truncation toward zero and saturation.
`default_nettype none
module v3alu_lane #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  v3alu_pkg::t_kind            i_kind,
    input  logic signed [WORD_BITS-1:0] i_a,
    input  logic signed [WORD_BITS-1:0] i_b,
    input  logic signed [WORD_BITS-1:0] i_f,
    input  logic signed [WORD_BITS-1:0] i_aj,
    input  logic signed [WORD_BITS-1:0] i_bk,
    input  logic signed [WORD_BITS-1:0] i_ak,
    input  logic signed [WORD_BITS-1:0] i_bj,
    output logic [WORD_BITS-1:0]        o_res,
    output logic                        o_ovf,
    output logic [2*WORD_BITS-1:0]      o_sq,
    output logic [WORD_BITS-1:0]        o_abs,
    output logic                        o_neg
);
    import v3alu_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2*W;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // stage A: operand selection, multipliers, add, subtract and negate
    logic signed [W-1:0]  m_l, m_r;
    logic signed [W:0]    n_simple;
    logic signed [PW-1:0] r_p1, r_p2;
    logic signed [W:0]    r_simple;
    logic [W-1:0]         r_abs_a;
    logic                 r_neg_a;
    t_kind                r_kind;

    always_comb begin
        case (i_kind)
            KIND_SCALE: begin
                m_l = i_a;
                m_r = i_f;
            end
            KIND_CROSS: begin
                m_l = i_aj;
                m_r = i_bk;
            end
            default: begin
                m_l = i_a;
                m_r = i_a;
            end
        endcase
        case (i_kind)
            KIND_ADD: n_simple = {i_a[W-1], i_a} + {i_b[W-1], i_b};
            KIND_SUB: n_simple = {i_a[W-1], i_a} - {i_b[W-1], i_b};
            KIND_NEG: n_simple = {(W+1){1'b0}} - {i_a[W-1], i_a};
            default:  n_simple = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1     <= m_l * m_r;
            r_p2     <= i_ak * i_bj;
            r_simple <= n_simple;
            r_abs_a  <= i_a[W-1] ? (~i_a + 1'b1) : i_a;
            r_neg_a  <= i_a[W-1];
            r_kind   <= i_kind;
        end
    end

    // stage B: cross difference, drop fraction toward zero, saturate
    logic signed [PW:0] d, d_bias, t;
    logic               t_ovf, s_ovf;
    logic [W-1:0]       t_val, s_val, n_res;
    logic               n_ovf;

    always_comb begin
        if (r_kind == KIND_CROSS) begin
            d = {r_p1[PW-1], r_p1} - {r_p2[PW-1], r_p2};
        end else begin
            d = {r_p1[PW-1], r_p1};
        end
        d_bias = d + {{(PW+1-F){1'b0}}, {F{d[PW]}}};
        t      = d_bias >>> F;
        t_ovf  = !((&t[PW:W-1]) || !(|t[PW:W-1]));
        t_val  = t_ovf ? (t[PW] ? SAT_MIN : SAT_MAX) : t[W-1:0];
        s_ovf  = r_simple[W] != r_simple[W-1];
        s_val  = s_ovf ? (r_simple[W] ? SAT_MIN : SAT_MAX) : r_simple[W-1:0];
        case (r_kind)
            KIND_ADD, KIND_SUB, KIND_NEG: begin
                n_res = s_val;
                n_ovf = s_ovf;
            end
            KIND_SCALE, KIND_CROSS: begin
                n_res = t_val;
                n_ovf = t_ovf;
            end
            default: begin
                n_res = '0;
                n_ovf = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res <= n_res;
            o_ovf <= n_ovf;
            o_sq  <= r_p1;
            o_abs <= r_abs_a;
            o_neg <= r_neg_a;
        end
    end
endmodule
`default_nettype wire

// File: rtl/v3alu_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module v3alu_sqrt #(
    parameter int WORD_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [2*WORD_BITS-1:0] i_rad,
    output logic [WORD_BITS-1:0]   o_root
);
    localparam int W = WORD_BITS;

    logic [W-1:0]   r_rem  [W];
    logic [W-1:0]   r_root [W];
    logic [2*W-1:0] r_rad  [W];
    logic [W-1:0]   n_rem  [W];
    logic [W-1:0]   n_root [W];
    logic [2*W-1:0] n_rad  [W];

    // each stage brings down two radicand bits and tries root*4+1
    always_comb begin
        logic [W-1:0]   rem_in;
        logic [W-1:0]   root_in;
        logic [2*W-1:0] rad_in;
        logic [W+1:0]   rem_sh;
        logic [W+1:0]   trial;
        for (int k = 0; k < W; k++) begin
            if (k == 0) begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = i_rad;
            end else begin
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
                rad_in  = r_rad[k-1];
            end
            rem_sh = {rem_in, rad_in[2*W-1 -: 2]};
            trial  = {root_in, 2'b01};
            if (rem_sh >= trial) begin
                n_rem[k]  = W'(rem_sh - trial);
                n_root[k] = {root_in[W-2:0], 1'b1};
            end else begin
                n_rem[k]  = W'(rem_sh);
                n_root[k] = {root_in[W-2:0], 1'b0};
            end
            n_rad[k] = {rad_in[2*W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_rad[k]  <= n_rad[k];
            end
        end
    end

    assign o_root = r_root[W-1];
endmodule
`default_nettype wire

// File: rtl/v3alu_div.sv
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
`default_nettype none
module v3alu_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [WORD_BITS+FRAC_BITS-1:0] i_num,
    input  logic [WORD_BITS-1:0]           i_den,
    output logic [WORD_BITS+FRAC_BITS-1:0] o_quo
);
    localparam int W  = WORD_BITS;
    localparam int QW = WORD_BITS + FRAC_BITS;

    logic [W-1:0]  r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [QW-1:0] r_num [QW];
    logic [W-1:0]  r_den [QW];
    logic [W-1:0]  n_rem [QW];
    logic [QW-1:0] n_quo [QW];
    logic [QW-1:0] n_num [QW];
    logic [W-1:0]  n_den [QW];

    // shift in one dividend bit, subtract the divisor where it fits
    always_comb begin
        logic [W-1:0]  rem_in;
        logic [QW-1:0] quo_in;
        logic [QW-1:0] num_in;
        logic [W-1:0]  den_in;
        logic [W:0]    rem_sh;
        logic          fits;
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                rem_in = '0;
                quo_in = '0;
                num_in = i_num;
                den_in = i_den;
            end else begin
                rem_in = r_rem[k-1];
                quo_in = r_quo[k-1];
                num_in = r_num[k-1];
                den_in = r_den[k-1];
            end
            rem_sh   = {rem_in, num_in[QW-1]};
            fits     = rem_sh >= {1'b0, den_in};
            n_rem[k] = fits ? W'(rem_sh - {1'b0, den_in}) : W'(rem_sh);
            n_quo[k] = {quo_in[QW-2:0], fits};
            n_num[k] = {num_in[QW-2:0], 1'b0};
            n_den[k] = den_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
                r_num[k] <= n_num[k];
                r_den[k] <= n_den[k];
            end
        end
    end

    assign o_quo = r_quo[QW-1];
endmodule
`default_nettype wire

// File: rtl/vec3_fixed_point_alu.sv
// Top level: three-lane fixed-point vector unit with square root and normalise.
// Takes one beat per cycle while the output is not stalled and returns one beat per
// input beat, in order. Every beat passes through the same pipeline (Q16.16 with the
// default parameters): the square root spends one stage per root bit and the three
// normalise dividers one stage per quotient bit. Three lanes handle x, y and z and
// share the magnitude. A stalled output holds the whole pipeline; input tready is
// high whenever the output register is empty or being taken.
`default_nettype none
module vec3_fixed_point_alu #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // ax, ay, az, bx, by_comp, bz, factor (lowest first)
    input  logic [((7*WORD_BITS+7)/8)*8-1:0]      s_axis_tdata,
    // kind
    input  logic [v3alu_pkg::KIND_W-1:0]          s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // rx, ry, rz, length, zero fill (lowest first)
    output logic [((4*WORD_BITS-1+7)/8)*8-1:0]    m_axis_tdata,
    // overflow, zero_length (lowest first)
    output logic [v3alu_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
    import v3alu_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int QW   = W + F;
    localparam int ODW  = ((4*W-1+7)/8)*8;
    localparam int VLEN = 4 + W + QW;
    localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        t_kind               kind;
        logic [2:0][W-1:0]   res;
        logic                ovf;
        logic [2:0][W-1:0]   abs_a;
        logic [2:0]          neg;
    } t_side1;

    typedef struct packed {
        t_kind               kind;
        logic [2:0][W-1:0]   res;
        logic                ovf;
        logic [W-2:0]        len;
        logic                zlen;
        logic [2:0]          neg;
    } t_side2;

    // pipeline advance and valid tracking
    logic            en;
    logic            r_out_vld;
    logic [VLEN-1:0] r_vld;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld     <= {r_vld[VLEN-2:0], s_axis_tvalid};
            r_out_vld <= r_vld[VLEN-1];
        end
    end

    // input register
    t_kind               r_kind1, r_kind2, r_kind3;
    logic signed [W-1:0] r_a [3];
    logic signed [W-1:0] r_b [3];
    logic signed [W-1:0] r_f;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind1 <= t_kind'(s_axis_tuser);
            for (int i = 0; i < 3; i++) begin
                r_a[i] <= s_axis_tdata[i*W +: W];
                r_b[i] <= s_axis_tdata[(i+3)*W +: W];
            end
            r_f     <= s_axis_tdata[6*W +: W];
            r_kind2 <= r_kind1;
            r_kind3 <= r_kind2;
        end
    end

    // component lanes
    logic [W-1:0]   w_res [3];
    logic           w_ovf [3];
    logic [2*W-1:0] w_sq  [3];
    logic [W-1:0]   w_abs [3];
    logic           w_neg [3];

    for (genvar g = 0; g < 3; g++) begin : g_lane
        v3alu_lane #(
            .WORD_BITS (W),
            .FRAC_BITS (F)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_kind (r_kind1),
            .i_a    (r_a[g]),
            .i_b    (r_b[g]),
            .i_f    (r_f),
            .i_aj   (r_a[(g+1)%3]),
            .i_bk   (r_b[(g+2)%3]),
            .i_ak   (r_a[(g+2)%3]),
            .i_bj   (r_b[(g+1)%3]),
            .o_res  (w_res[g]),
            .o_ovf  (w_ovf[g]),
            .o_sq   (w_sq[g]),
            .o_abs  (w_abs[g]),
            .o_neg  (w_neg[g])
        );
    end

    // merge: sum of squares and side data
    logic [2*W-1:0] r_sum;
    t_side1         r_side1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum         <= w_sq[0] + w_sq[1] + w_sq[2];
            r_side1.kind  <= r_kind3;
            r_side1.ovf   <= w_ovf[0] | w_ovf[1] | w_ovf[2];
            for (int i = 0; i < 3; i++) begin
                r_side1.res[i]   <= w_res[i];
                r_side1.abs_a[i] <= w_abs[i];
                r_side1.neg[i]   <= w_neg[i];
            end
        end
    end

    // magnitude
    logic [W-1:0] w_root;
    t_side1       w_side1_d;

    v3alu_sqrt #(
        .WORD_BITS (W)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    v3alu_delay #(
        .WIDTH ($bits(t_side1)),
        .DEPTH (W)
    ) u_dly_sqrt (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r_side1),
        .o_q   (w_side1_d)
    );

    // length, its saturation and the zero-vector case
    t_side2 n_side2;

    always_comb begin
        n_side2.kind = w_side1_d.kind;
        n_side2.res  = w_side1_d.res;
        n_side2.neg  = w_side1_d.neg;
        n_side2.ovf  = w_side1_d.ovf;
        n_side2.len  = '0;
        n_side2.zlen = 1'b0;
        case (w_side1_d.kind)
            KIND_MAG: begin
                n_side2.len = w_root[W-1] ? {(W-1){1'b1}} : w_root[W-2:0];
                n_side2.ovf = w_side1_d.ovf | w_root[W-1];
            end
            KIND_NORM: begin
                if (w_root == '0) begin
                    n_side2.zlen = 1'b1;
                end else begin
                    n_side2.len = w_root[W-1] ? {(W-1){1'b1}} : w_root[W-2:0];
                    n_side2.ovf = w_side1_d.ovf | w_root[W-1];
                end
            end
            default: begin
                n_side2.len = '0;
            end
        endcase
    end

    // normalise dividers, one per lane
    logic [QW-1:0] w_quo [3];
    t_side2        w_side2_d;

    for (genvar g = 0; g < 3; g++) begin : g_div
        v3alu_div #(
            .WORD_BITS (W),
            .FRAC_BITS (F)
        ) u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num ({w_side1_d.abs_a[g], {F{1'b0}}}),
            .i_den (w_root),
            .o_quo (w_quo[g])
        );
    end

    v3alu_delay #(
        .WIDTH ($bits(t_side2)),
        .DEPTH (QW)
    ) u_dly_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (n_side2),
        .o_q   (w_side2_d)
    );

    // final selection with signed saturation of the quotients
    logic [2:0][W-1:0] n_out_res;
    logic              n_out_ovf;

    always_comb begin
        logic         q_ovf;
        logic [W-1:0] q_val;
        n_out_res = w_side2_d.res;
        n_out_ovf = w_side2_d.ovf;
        for (int i = 0; i < 3; i++) begin
            if (w_side2_d.neg[i]) begin
                q_ovf = (|w_quo[i][QW-1:W]) || (w_quo[i][W-1] && (|w_quo[i][W-2:0]));
                q_val = q_ovf ? SAT_MIN : (~w_quo[i][W-1:0] + 1'b1);
            end else begin
                q_ovf = |w_quo[i][QW-1:W-1];
                q_val = q_ovf ? SAT_MAX : w_quo[i][W-1:0];
            end
            if (w_side2_d.kind == KIND_NORM && !w_side2_d.zlen) begin
                n_out_res[i] = q_val;
                n_out_ovf    = n_out_ovf | q_ovf;
            end
        end
    end

    // output register
    logic [ODW-1:0]        r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data                 <= {{(ODW-4*W+1){1'b0}}, w_side2_d.len, n_out_res};
            r_out_user[USER_OVF]       <= n_out_ovf;
            r_out_user[USER_ZLEN]      <= w_side2_d.zlen;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
endmodule
`default_nettype wire

// File: rtl/v3alu_checker.sv
// Port-level checks on the vector unit, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module v3alu_checker #(
    parameter int WORD_BITS = 32
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  s_axis_tready,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((4*WORD_BITS-1+7)/8)*8-1:0]    m_axis_tdata,
    input logic [v3alu_pkg::OUT_USER_W-1:0]      m_axis_tuser
);
    import v3alu_pkg::*;

    localparam int RW = 4*WORD_BITS - 1;

    // reset empties the output register
    `ASSERT_CLK(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")

    // a held output beat stalls the input side
    `ASSERT_CLK_RST(a_stall_in, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalled")

    // an empty output register never blocks the input
    `ASSERT_CLK_RST(a_ready_free, i_clk, i_rst_n,
        !m_axis_tvalid |-> s_axis_tready, "input blocked with empty output")

    // a stalled beat keeps its data
    `ASSERT_CLK_RST(a_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled beat changed")

    // a zero-length normalise gives an all-zero result without overflow
    `ASSERT_CLK_RST(a_zlen, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser[USER_ZLEN] |->
            m_axis_tdata[RW-1:0] == '0 && !m_axis_tuser[USER_OVF],
        "zero length result not clear")
endmodule

bind vec3_fixed_point_alu v3alu_checker #(
    .WORD_BITS (WORD_BITS)
) u_v3alu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
